/* rtl/core/mwrm_pkg.sv */
package mwrm_pkg;

  localparam int COUNT_BITS = 48;
  localparam int TIME_BITS  = 48;
  localparam int RATE_BITS  = 31;
  localparam int NUM_WIN    = 5;
  localparam int WIN_W      = $clog2(NUM_WIN);

  // count delta times 1000
  localparam int PROD_BITS  = COUNT_BITS + 10;
  // product bits above the rate field
  localparam int HIGH_BITS  = PROD_BITS - RATE_BITS;
  localparam int CMP_BITS   = (HIGH_BITS > TIME_BITS) ? HIGH_BITS : TIME_BITS;
  localparam int ITER_W     = $clog2(TIME_BITS + 1);

  // elapsed microseconds to milliseconds, one byte per step
  localparam int MS_DIGITS  = (TIME_BITS + 7) / 8;
  localparam int MS_PAD     = MS_DIGITS * 8;
  localparam int MS_STEP_W  = $clog2(MS_DIGITS + 1);
  // floor(v / 1000) == (v * MS_RECIP) >> MS_SHIFT for every v below 256000
  localparam int MS_SHIFT   = 28;
  localparam logic [18:0] MS_RECIP = 19'd268436;

  localparam logic [RATE_BITS-1:0] RATE_MAX = '1;
  localparam logic [9:0]           US_PER_MS = 10'd1000;

  // window index codes
  localparam logic [WIN_W-1:0] WIN_10S = WIN_W'(0);
  localparam logic [WIN_W-1:0] WIN_30S = WIN_W'(1);
  localparam logic [WIN_W-1:0] WIN_1M  = WIN_W'(2);
  localparam logic [WIN_W-1:0] WIN_5M  = WIN_W'(3);
  localparam logic [WIN_W-1:0] WIN_60M = WIN_W'(4);

  // window span in microseconds
  function automatic logic [31:0] span_us(logic [WIN_W-1:0] w);
    logic [31:0] s;
    case (w)
      WIN_10S: s = 32'd10000000;
      WIN_30S: s = 32'd30000000;
      WIN_1M:  s = 32'd60000000;
      WIN_5M:  s = 32'd300000000;
      WIN_60M: s = 32'd3600000000;
      default: s = '1;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic [COUNT_BITS-1:0] event_count;
    logic [TIME_BITS-1:0]  now_us;
  } sample_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] rate_10s;
    logic [RATE_BITS-1:0] rate_30s;
    logic [RATE_BITS-1:0] rate_1m;
    logic [RATE_BITS-1:0] rate_5m;
    logic [RATE_BITS-1:0] rate_60m;
  } rates_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] dividend;
    logic [TIME_BITS-1:0] divisor;
    logic [TIME_BITS-1:0] rem_init;
    logic [ITER_W-1:0]    iters;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TIME_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/mwrm_div.sv */
module mwrm_div (
  input  logic               clk,
  input  logic               rst,
  input  mwrm_pkg::div_req_t req,
  output mwrm_pkg::div_rsp_t rsp
);
  import mwrm_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic                 busy;
  logic                 done;
  logic [ITER_W-1:0]    cnt;
  logic [TIME_BITS-1:0] dvd;
  logic [TIME_BITS-1:0] dvs;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] quo;

  logic [TIME_BITS:0]   shifted;
  logic [TIME_BITS:0]   diff;
  logic                 ge;

  assign shifted = {rem, dvd[TIME_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == ITER_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= req.rem_init;
      quo <= '0;
      cnt <= req.iters;
    end else if (busy) begin
      dvd <= {dvd[TIME_BITS-2:0], 1'b0};
      rem <= ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quo <= {quo[TIME_BITS-2:0], ge};
      cnt <= cnt - ITER_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/core/multi_window_rate_meter_unit.sv */
// a sample steps through the windows in turn, then S_DONE loads rates; each due window adds
//   the byte-wise ms step (S_MS) and a serial division (S_RATE, S_RATE_WAIT),
//   only the ms step and S_RATE when its delta is zero or its rate saturates
// throughput: sample_stall holds off new samples until the sweep is back in idle; the byte-wise
//   ms step and the shared serial divider set the worst case, with all five windows due
// reset (synchronous, active high) clears the sequencer, all window valid bits and rates_valid
module multi_window_rate_meter_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  mwrm_pkg::sample_t sample,
  output logic              rates_valid,
  input  logic              rates_stall,
  output mwrm_pkg::rates_t  rates
);
  import mwrm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_CHECK     = 6'b000010,
    S_MS        = 6'b000100,
    S_RATE      = 6'b001000,
    S_RATE_WAIT = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [WIN_W-1:0] win, win_next;

  // latched sample
  logic [COUNT_BITS-1:0] cnt;
  logic [TIME_BITS-1:0]  now;

  // per-window working values
  logic [COUNT_BITS-1:0] delta;
  logic [MS_PAD-1:0]     elapsed;
  logic [PROD_BITS-1:0]  prod;
  logic [TIME_BITS-1:0]  ms;

  // millisecond step: remainder and remaining bytes
  logic [9:0]            ms_rem;
  logic [MS_STEP_W-1:0]  ms_step;
  logic [17:0]           ms_v;
  logic [35:0]           ms_prod;
  logic [7:0]            ms_q;
  logic [17:0]           ms_diff;

  // window state
  logic [COUNT_BITS-1:0] win_total [NUM_WIN];
  logic [TIME_BITS-1:0]  win_time  [NUM_WIN];
  logic [RATE_BITS-1:0]  win_rate  [NUM_WIN];
  logic [NUM_WIN-1:0]    win_valid;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  accept;
  logic                  last;
  logic                  rebase;
  logic                  due;
  logic [TIME_BITS-1:0]  elapsed_c;
  logic [CMP_BITS-1:0]   high_part;
  logic                  sat;
  logic                  zero_delta;
  logic [RATE_BITS-1:0]  quo_rate;
  logic                  upd_en;
  logic [RATE_BITS-1:0]  upd_rate;
  logic                  out_free;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign last         = (win == WIN_W'(NUM_WIN - 1));
  assign out_free     = !rates_valid || !rates_stall;

  // unset or count went backwards: re-base this window
  assign rebase    = !win_valid[win] || (cnt < win_total[win]);
  assign elapsed_c = now - win_time[win];
  // time going backwards never makes a window due
  assign due       = (now >= win_time[win]) && (elapsed_c >= TIME_BITS'(span_us(win)));

  // elapsed / 1000 one byte at a time, top byte first, by reciprocal multiply
  assign ms_v    = {ms_rem, elapsed[MS_PAD-1 -: 8]};
  assign ms_prod = 36'(ms_v) * 36'(MS_RECIP);
  assign ms_q    = ms_prod[MS_SHIFT +: 8];
  assign ms_diff = ms_v - 18'(ms_q) * 18'(US_PER_MS);

  // quotient reaches 2^31 exactly when the product over 2^31 reaches ms
  assign high_part  = CMP_BITS'(prod >> RATE_BITS);
  assign sat        = high_part >= CMP_BITS'(ms);
  assign zero_delta = (delta == '0);
  assign quo_rate   = div_rsp.quotient[RATE_BITS-1:0];

  // window update and next-state
  always_comb begin
    upd_en     = 1'b0;
    upd_rate   = '0;
    state_next = state;
    win_next   = win;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CHECK;
          win_next   = '0;
        end
      end
      S_CHECK: begin
        if (rebase) begin
          upd_en = 1'b1;
        end else if (due) begin
          state_next = S_MS;
        end
      end
      S_MS: begin
        // last byte of the elapsed time
        if (ms_step == MS_STEP_W'(1)) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        if (zero_delta) begin
          upd_en = 1'b1;
        end else if (sat) begin
          upd_en   = 1'b1;
          upd_rate = RATE_MAX;
        end else begin
          state_next = S_RATE_WAIT;
        end
      end
      S_RATE_WAIT: begin
        if (div_rsp.done) begin
          upd_en   = 1'b1;
          // a rise that truncates to zero still reports one
          upd_rate = (quo_rate == '0) ? RATE_BITS'(1) : quo_rate;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // window finished: step to the next or wrap up
    if (upd_en || (state == S_CHECK && !rebase && !due)) begin
      if (last) begin
        state_next = S_DONE;
      end else begin
        state_next = S_CHECK;
        win_next   = win + WIN_W'(1);
      end
    end
  end

  // rate division: low rate bits shift in, the high part starts as the partial remainder
  always_comb begin
    div_req.start    = (state == S_RATE) && !zero_delta && !sat;
    div_req.iters    = ITER_W'(RATE_BITS);
    div_req.dividend = {prod[RATE_BITS-1:0], {(TIME_BITS - RATE_BITS){1'b0}}};
    div_req.divisor  = ms;
    div_req.rem_init = TIME_BITS'(high_part);
  end

  mwrm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      win         <= '0;
      win_valid   <= '0;
      rates_valid <= 1'b0;
    end else begin
      state <= state_next;
      win   <= win_next;
      if (upd_en) begin
        win_valid[win] <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        rates_valid <= 1'b1;
      end else if (rates_valid && !rates_stall) begin
        rates_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= sample.event_count;
      now <= sample.now_us;
    end
    if (state == S_CHECK) begin
      delta   <= cnt - win_total[win];
      elapsed <= MS_PAD'(elapsed_c);
      ms_rem  <= '0;
      ms_step <= MS_STEP_W'(MS_DIGITS);
    end
    if (state == S_MS) begin
      // times 1000 as 1024 - 16 - 8
      prod <= (PROD_BITS'(delta) << 10) - (PROD_BITS'(delta) << 4)
            - (PROD_BITS'(delta) << 3);
      elapsed <= {elapsed[MS_PAD-9:0], 8'd0};
      ms_rem  <= ms_diff[9:0];
      ms_step <= ms_step - MS_STEP_W'(1);
      ms      <= {ms[TIME_BITS-9:0], ms_q};
    end
    if (upd_en) begin
      win_total[win] <= cnt;
      win_time[win]  <= now;
      win_rate[win]  <= upd_rate;
    end
    if (state == S_DONE && out_free) begin
      rates.rate_10s <= win_rate[WIN_10S];
      rates.rate_30s <= win_rate[WIN_30S];
      rates.rate_1m  <= win_rate[WIN_1M];
      rates.rate_5m  <= win_rate[WIN_5M];
      rates.rate_60m <= win_rate[WIN_60M];
    end
  end

  // a sample transfer always starts the sweep at the first window
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CHECK && win == '0))
    else $error("sweep did not start at first window");

  // divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_RATE_WAIT))
    else $error("divider done outside a wait state");

  // a finished sweep loads the result and frees the input
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (rates_valid && state == S_IDLE))
    else $error("result not loaded at end of sweep");

  // every window update leaves that window set
  assert property (@(posedge clk) disable iff (rst)
    upd_en |=> win_valid[$past(win)])
    else $error("updated window not marked valid");

endmodule
